FILE: sv/assert_macros.svh
// Assertion macros shared by the odometry RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Delayed implication, disabled during reset.
`define ASSERT_AFTER3(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
      else $error("assertion failed: three-cycle implication");

`endif

FILE: sv/weo_pkg.sv
// Types and constants for the wheel encoder odometry block.
// No dependencies; used by weo_ctrl, weo_dp and the top level.
package weo_pkg;

   typedef struct packed {
      logic [15:0] left_count;
      logic [15:0] right_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] left_ticks;
      logic signed [31:0] right_ticks;
      logic signed [47:0] left_angle;
      logic signed [47:0] right_angle;
      logic signed [39:0] left_speed;
      logic signed [39:0] right_speed;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_WEIGHT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic baseline;
      logic capture;
      logic scale;
      logic weight;
      logic emit;
   } cmd_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_POSITION_SCALE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VELOCITY_SCALE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING      = 2'd2;

   localparam logic [23:0] POSITION_SCALE_RESET = 24'd87845;
   localparam logic [23:0] VELOCITY_SCALE_RESET = 24'd34315;
   localparam logic [16:0] SMOOTHING_RESET      = 17'd32768;

   localparam logic [16:0] UNITY = 17'd65536;

endpackage

FILE: sv/weo_ctrl.sv
// Sequencer for the odometry block: handshakes, priming flag and stage commands.
// Depends on weo_pkg and assert_macros.svh.
`include "assert_macros.svh"

module weo_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output weo_pkg::cmd_type   cmd
);

   weo_pkg::state_type state_ff, state_in;
   logic primed_ff, primed_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= weo_pkg::ST_IDLE;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         weo_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // first item after reset only sets the baseline
               if (primed_ff) begin
                  cmd.capture = 1'b1;
                  state_in    = weo_pkg::ST_SCALE;
               end else begin
                  cmd.baseline = 1'b1;
               end
            end
         end
         weo_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = weo_pkg::ST_WEIGHT;
         end
         weo_pkg::ST_WEIGHT: begin
            cmd.weight = 1'b1;
            state_in   = weo_pkg::ST_EMIT;
         end
         weo_pkg::ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = weo_pkg::ST_IDLE;
            end
         end
         default: state_in = weo_pkg::ST_IDLE;
      endcase
   end

   assign primed_in    = primed_ff | cmd.baseline;
   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   `ASSERT_IMPLIES(a_emit_into_free_slot, clock, reset, cmd.emit, (!rsp_valid_ff || rsp_ready))
   `ASSERT_NEXT(a_emit_shows_result, clock, reset, cmd.emit, rsp_valid_ff)
   `ASSERT_IMPLIES(a_no_result_unprimed, clock, reset, !primed_ff, !rsp_valid_ff)
   `ASSERT_AFTER3(a_capture_reaches_emit, clock, reset, (req_valid && req_ready && primed_ff), (state_ff == weo_pkg::ST_EMIT))

endmodule

FILE: sv/weo_dp.sv
// Datapath for the odometry block: configuration registers, wheel state,
// multiply stages and the output register. Depends on weo_pkg.
module weo_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  weo_pkg::cmd_type                    cmd,
   input  weo_pkg::req_type                    req_data,
   output weo_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [weo_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [weo_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // wrapped difference of two readings, -32768..32768 in 17 bits
   function automatic logic signed [16:0] wrap_diff(input logic [15:0] old_v,
                                                    input logic [15:0] now_v);
      logic [15:0] d;
      d = now_v - old_v;
      if (d == 16'h8000) begin
         wrap_diff = (now_v > old_v) ? -17'sd32768 : 17'sd32768;
      end else begin
         wrap_diff = $signed({d[15], d});
      end
   endfunction

   // configuration
   logic [23:0] pos_scale_ff;
   logic [23:0] vel_scale_ff;
   logic [16:0] smoothing_ff;

   // wheel state
   logic [15:0]        left_prev_ff, right_prev_ff;
   logic signed [31:0] left_total_ff, right_total_ff;
   logic signed [39:0] left_filt_ff, right_filt_ff;

   // pipeline payload
   logic signed [16:0] left_ndiff_ff, right_ndiff_ff;
   logic signed [47:0] left_angle_ff, right_angle_ff;
   logic signed [39:0] left_vel_ff, right_vel_ff;
   logic signed [57:0] left_av_ff, right_av_ff;
   logic signed [57:0] left_by_ff, right_by_ff;
   weo_pkg::rsp_type   rsp_ff;

   logic signed [16:0] left_diff, right_diff;
   logic signed [31:0] left_total_in, right_total_in;
   logic signed [57:0] left_angle_prod, right_angle_prod;
   logic signed [41:0] left_vel_prod, right_vel_prod;
   logic [16:0]        weight_a, weight_b;
   logic signed [57:0] left_av_in, right_av_in, left_by_in, right_by_in;
   logic signed [57:0] left_sum, right_sum;
   logic signed [39:0] left_speed_in, right_speed_in;

   assign left_diff      = wrap_diff(left_prev_ff, req_data.left_count);
   assign right_diff     = wrap_diff(right_prev_ff, req_data.right_count);
   // encoders are mounted reversed: subtract the difference
   assign left_total_in  = left_total_ff - 32'(left_diff);
   assign right_total_in = right_total_ff - 32'(right_diff);

   assign left_angle_prod  = left_total_ff * $signed({1'b0, pos_scale_ff});
   assign right_angle_prod = right_total_ff * $signed({1'b0, pos_scale_ff});
   assign left_vel_prod    = left_ndiff_ff * $signed({1'b0, vel_scale_ff});
   assign right_vel_prod   = right_ndiff_ff * $signed({1'b0, vel_scale_ff});

   // saturate the filter weight at unity
   assign weight_a = (smoothing_ff[16] && (|smoothing_ff[15:0])) ? weo_pkg::UNITY
                                                                 : smoothing_ff;
   assign weight_b = weo_pkg::UNITY - weight_a;

   assign left_av_in  = $signed({1'b0, weight_a}) * left_vel_ff;
   assign right_av_in = $signed({1'b0, weight_a}) * right_vel_ff;
   assign left_by_in  = $signed({1'b0, weight_b}) * left_filt_ff;
   assign right_by_in = $signed({1'b0, weight_b}) * right_filt_ff;

   assign left_sum       = left_av_ff + left_by_ff;
   assign right_sum      = right_av_ff + right_by_ff;
   // floor shift by 16; the filtered value always fits 40 bits
   assign left_speed_in  = left_sum[55:16];
   assign right_speed_in = right_sum[55:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_scale_ff   <= weo_pkg::POSITION_SCALE_RESET;
         vel_scale_ff   <= weo_pkg::VELOCITY_SCALE_RESET;
         smoothing_ff   <= weo_pkg::SMOOTHING_RESET;
         left_prev_ff   <= '0;
         right_prev_ff  <= '0;
         left_total_ff  <= '0;
         right_total_ff <= '0;
         left_filt_ff   <= '0;
         right_filt_ff  <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               weo_pkg::CSR_POSITION_SCALE: pos_scale_ff <= csr_wdata;
               weo_pkg::CSR_VELOCITY_SCALE: vel_scale_ff <= csr_wdata;
               weo_pkg::CSR_SMOOTHING:      smoothing_ff <= csr_wdata[16:0];
               default: ;
            endcase
         end
         if (cmd.baseline || cmd.capture) begin
            left_prev_ff  <= req_data.left_count;
            right_prev_ff <= req_data.right_count;
         end
         if (cmd.capture) begin
            left_total_ff  <= left_total_in;
            right_total_ff <= right_total_in;
         end
         if (cmd.emit) begin
            left_filt_ff  <= left_speed_in;
            right_filt_ff <= right_speed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         left_ndiff_ff  <= -left_diff;
         right_ndiff_ff <= -right_diff;
      end
      if (cmd.scale) begin
         left_angle_ff  <= left_angle_prod[55:8];
         right_angle_ff <= right_angle_prod[55:8];
         left_vel_ff    <= left_vel_prod[39:0];
         right_vel_ff   <= right_vel_prod[39:0];
      end
      if (cmd.weight) begin
         left_av_ff  <= left_av_in;
         right_av_ff <= right_av_in;
         left_by_ff  <= left_by_in;
         right_by_ff <= right_by_in;
      end
      if (cmd.emit) begin
         rsp_ff.left_ticks  <= left_total_ff;
         rsp_ff.right_ticks <= right_total_ff;
         rsp_ff.left_angle  <= left_angle_ff;
         rsp_ff.right_angle <= right_angle_ff;
         rsp_ff.left_speed  <= left_speed_in;
         rsp_ff.right_speed <= right_speed_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: sv/wheel_encoder_odometry.sv
// Wheel encoder odometry: tick totals, Q32.16 angles and smoothed Q24.16 speeds.
// An accepted item goes through the scale multiply, the filter multiply and the filter sum;
// no new item is taken until its result is emitted, which waits for a free output register.
// The first item after reset only stores the baseline readings and gives no result.
// Synchronous reset clears control, wheel state and restores register defaults.
// Depends on weo_pkg, weo_ctrl and weo_dp.
module wheel_encoder_odometry (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  weo_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output weo_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [weo_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [weo_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   weo_pkg::cmd_type cmd;

   weo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   weo_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
